### hdl/mlsr_pkg.sv
package mlsr_pkg;

    localparam logic [3:0] OP_READ     = 4'd0;
    localparam logic [3:0] OP_WRITE    = 4'd1;
    localparam logic [3:0] OP_RX_CHAR  = 4'd2;
    localparam logic [3:0] OP_RX_BREAK = 4'd3;
    localparam logic [3:0] OP_TX_DONE  = 4'd4;
    localparam logic [3:0] OP_CONNECT  = 4'd5;
    localparam logic [3:0] OP_DISCONN  = 4'd6;
    localparam logic [3:0] OP_RX_IACK  = 4'd7;
    localparam logic [3:0] OP_TX_IACK  = 4'd8;

    localparam logic [1:0] CFG_BASE_ADDR  = 2'd0;
    localparam logic [1:0] CFG_BASE_VEC   = 2'd1;
    localparam logic [1:0] CFG_LINES      = 2'd2;
    localparam logic [1:0] CFG_MODEM_MASK = 2'd3;

    localparam logic [1:0] REG_RXCSR = 2'd0;
    localparam logic [1:0] REG_RXBUF = 2'd1;
    localparam logic [1:0] REG_TXCSR = 2'd2;
    localparam logic [1:0] REG_TXBUF = 2'd3;

    localparam logic [15:0] RXC_DSI  = 16'o100000;
    localparam logic [15:0] RXC_RNG  = 16'o040000;
    localparam logic [15:0] RXC_CTS  = 16'o020000;
    localparam logic [15:0] RXC_CDT  = 16'o010000;
    localparam logic [15:0] RXC_SEC  = 16'o002000;
    localparam logic [15:0] RXC_DONE = 16'o000200;
    localparam logic [15:0] CSR_IE   = 16'o000100;
    localparam logic [15:0] RXC_DSIE = 16'o000040;
    localparam logic [15:0] RXC_SECX = 16'o000010;
    localparam logic [15:0] RXC_RTS  = 16'o000004;
    localparam logic [15:0] RXC_DTR  = 16'o000002;
    localparam logic [15:0] RXC_RD   = RXC_DONE | CSR_IE;
    localparam logic [15:0] RXC_WR   = CSR_IE;
    localparam logic [15:0] RXC_RD_M = RXC_DSI | RXC_RNG | RXC_CTS | RXC_CDT | RXC_SEC
                                     | RXC_DONE | CSR_IE | RXC_DSIE | RXC_SECX
                                     | RXC_RTS | RXC_DTR;
    localparam logic [15:0] RXC_WR_M = CSR_IE | RXC_DSIE | RXC_SECX | RXC_RTS | RXC_DTR;
    localparam logic [15:0] RXB_ERR  = 16'o100000;
    localparam logic [15:0] RXB_OVR  = 16'o040000;
    localparam logic [15:0] RXB_BRK  = 16'o020000;
    localparam logic [15:0] RXB_RD   = RXB_ERR | RXB_OVR | RXB_BRK | 16'o000377;
    localparam logic [7:0]  TXC_DONE = 8'o200;
    localparam logic [7:0]  TXC_IE   = 8'o100;
    localparam logic [7:0]  TXC_RD   = 8'o200 | 8'o100 | 8'o004 | 8'o001;
    localparam logic [7:0]  TXC_WR   = 8'o100 | 8'o004 | 8'o001;
    localparam logic [9:0]  LINE_SPAN = 10'o010;
    localparam logic [9:0]  TX_VEC_OFS = 10'd4;

    // word accepted from the input channel
    typedef struct packed {
        logic [3:0]  opcode;
        logic [12:0] bus_address;
        logic [15:0] write_data;
        logic [3:0]  event_line;
        logic [7:0]  rx_char;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [15:0] read_data;
        logic        bus_error;
        logic        rx_irq;
        logic        tx_irq;
        logic [9:0]  vector;
        logic        vector_valid;
        logic        tx_valid;
        logic [7:0]  tx_char;
        logic        hangup;
    } out_word_t;

    // priority encoder result
    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } pick_t;

endpackage

### hdl/mlsr_prio_enc.sv
module mlsr_prio_enc #(
    parameter int NUM_LINES = 16
) (
    input  logic [NUM_LINES-1:0] req,
    output mlsr_pkg::pick_t      pick
);
    // lowest-numbered pending line wins
    always_comb begin
        pick = '0;
        for (int i = NUM_LINES - 1; i >= 0; i--) begin
            if (req[i]) begin
                pick.found = 1'b1;
                pick.idx   = 4'(i);
            end
        end
    end
endmodule

### hdl/multiline_serial_register_file_unit.sv
// channel   | ports                                        | handshake
// input     | s_opcode s_bus_address s_write_data s_event_line s_rx_char | s_valid/s_ready
// result    | m_read_data .. m_hangup (nine fields)        | m_valid/m_ready
// config    | cfg_we cfg_index cfg_data                    | write enable, no wait
//
// one word per cycle unless m_ready stalls the output: the word is registered, processed
// against the per-line flops in one pass, and the result is then registered in the output register
// the input register refills whenever it is empty or its word moves to the output
// reset clears every line register (transmit done set) and the configuration (line count set to 16)
// a stall on m_ready holds both stages; s_ready drops only when both are full
module multiline_serial_register_file_unit #(
    parameter int NUM_LINES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_opcode,
    input  logic [12:0] s_bus_address,
    input  logic [15:0] s_write_data,
    input  logic [3:0]  s_event_line,
    input  logic [7:0]  s_rx_char,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_read_data,
    output logic        m_bus_error,
    output logic        m_rx_irq,
    output logic        m_tx_irq,
    output logic [9:0]  m_vector,
    output logic        m_vector_valid,
    output logic        m_tx_valid,
    output logic [7:0]  m_tx_char,
    output logic        m_hangup
);
    localparam int LW = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

    // configuration
    logic [12:0] base_addr_reg;
    logic [8:0]  base_vec_reg;
    logic [4:0]  lines_reg;
    logic [15:0] modem_mask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_addr_reg  <= '0;
            base_vec_reg   <= '0;
            lines_reg      <= 5'd16;
            modem_mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                mlsr_pkg::CFG_BASE_ADDR:  base_addr_reg  <= cfg_data[12:0];
                mlsr_pkg::CFG_BASE_VEC:   base_vec_reg   <= cfg_data[8:0];
                mlsr_pkg::CFG_LINES:      lines_reg      <= cfg_data[4:0];
                mlsr_pkg::CFG_MODEM_MASK: modem_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // line state
    logic [15:0] rx_status_reg [NUM_LINES];
    logic [15:0] rx_buffer_reg [NUM_LINES];
    logic [7:0]  tx_status_reg [NUM_LINES];
    logic [7:0]  tx_buffer_reg [NUM_LINES];
    logic [NUM_LINES-1:0] rx_req_reg, ds_req_reg, tx_req_reg, conn_reg;
    logic [NUM_LINES-1:0] rx_req_next, ds_req_next, tx_req_next, conn_next;
    logic [15:0] rxs_next;
    logic [15:0] rxb_next;
    logic [7:0]  txs_next;
    logic [7:0]  txb_next;

    // input and output registers
    mlsr_pkg::in_word_t  in_reg;
    mlsr_pkg::out_word_t out_reg, out_next;
    logic in_full_reg, out_full_reg;
    logic advance;

    assign advance = in_full_reg && (!out_full_reg || m_ready);
    assign s_ready = !in_full_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            if (s_ready) in_full_reg <= s_valid;
            if (advance) out_full_reg <= 1'b1;
            else if (m_ready) out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg.opcode      <= s_opcode;
            in_reg.bus_address <= s_bus_address;
            in_reg.write_data  <= s_write_data;
            in_reg.event_line  <= s_event_line;
            in_reg.rx_char     <= s_rx_char;
        end
        if (advance) out_reg <= out_next;
    end

    // decode
    logic [4:0]  active;
    logic [12:0] off;
    logic [9:0]  bus_ln_wide;
    logic        addr_ok;
    logic [LW-1:0] bln, eln, ln;
    logic        ev_ok, is_bus;
    logic [1:0]  rsel;
    logic        odd;

    assign active      = (lines_reg > 5'(NUM_LINES)) ? 5'(NUM_LINES) : lines_reg;
    assign off         = in_reg.bus_address - base_addr_reg;
    assign bus_ln_wide = off[12:3];
    assign addr_ok     = (in_reg.bus_address >= base_addr_reg)
                      && (bus_ln_wide < 10'(active));
    assign bln   = off[3+LW-1:3];
    assign eln   = in_reg.event_line[LW-1:0];
    assign ev_ok = {1'b0, in_reg.event_line} < active;
    assign is_bus = (in_reg.opcode == mlsr_pkg::OP_READ)
                 || (in_reg.opcode == mlsr_pkg::OP_WRITE);
    assign ln    = is_bus ? bln : eln;
    assign rsel  = in_reg.bus_address[2:1];
    assign odd   = in_reg.bus_address[0];

    logic [15:0] rxs, rxb;
    logic [7:0]  txs, txb;
    logic        modem, conn;
    assign rxs   = rx_status_reg[ln];
    assign rxb   = rx_buffer_reg[ln];
    assign txs   = tx_status_reg[ln];
    assign txb   = tx_buffer_reg[ln];
    assign modem = modem_mask_reg[in_reg.event_line] && !is_bus
                || modem_mask_reg[off[6:3]] && is_bus;
    assign conn  = conn_reg[ln];

    // interrupt acknowledge lookup
    mlsr_pkg::pick_t rx_pick, tx_pick;
    mlsr_prio_enc #(.NUM_LINES(NUM_LINES)) u_rx_enc (
        .req (rx_req_reg | ds_req_reg),
        .pick(rx_pick)
    );
    mlsr_prio_enc #(.NUM_LINES(NUM_LINES)) u_tx_enc (
        .req (tx_req_reg),
        .pick(tx_pick)
    );

    // one pass of the selected operation
    logic [NUM_LINES-1:0] bit_ln;
    logic [15:0] d, csr, c;
    logic        wr_line;
    assign bit_ln = NUM_LINES'(1) << ln;
    assign d = in_reg.write_data;

    always_comb begin
        rx_req_next = rx_req_reg;
        ds_req_next = ds_req_reg;
        tx_req_next = tx_req_reg;
        conn_next   = conn_reg;
        rxs_next    = rxs;
        rxb_next    = rxb;
        txs_next    = txs;
        txb_next    = txb;
        wr_line     = 1'b0;
        out_next    = '0;
        csr         = rxs;
        c           = '0;
        unique case (in_reg.opcode)
            mlsr_pkg::OP_READ: begin
                if (!addr_ok) begin
                    out_next.bus_error = 1'b1;
                end else begin
                    wr_line = 1'b1;
                    unique case (rsel)
                        mlsr_pkg::REG_RXCSR: begin
                            out_next.read_data = rxs & (modem ? mlsr_pkg::RXC_RD_M
                                                              : mlsr_pkg::RXC_RD);
                            rxs_next = rxs & ~mlsr_pkg::RXC_DSI;
                            ds_req_next = ds_req_reg & ~bit_ln;
                        end
                        mlsr_pkg::REG_RXBUF: begin
                            out_next.read_data = rxb & mlsr_pkg::RXB_RD;
                            rxs_next = rxs & ~mlsr_pkg::RXC_DONE;
                            rx_req_next = rx_req_reg & ~bit_ln;
                        end
                        mlsr_pkg::REG_TXCSR: out_next.read_data = {8'd0, txs & mlsr_pkg::TXC_RD};
                        default:             out_next.read_data = {8'd0, txb};
                    endcase
                end
            end
            mlsr_pkg::OP_WRITE: begin
                if (!addr_ok) begin
                    out_next.bus_error = 1'b1;
                end else begin
                    wr_line = 1'b1;
                    unique case (rsel)
                        mlsr_pkg::REG_RXCSR: begin
                            if (!odd) begin
                                if ((d & mlsr_pkg::CSR_IE) == '0)
                                    rx_req_next = rx_req_reg & ~bit_ln;
                                else if ((csr & mlsr_pkg::RXC_RD) == mlsr_pkg::RXC_DONE)
                                    rx_req_next = rx_req_reg | bit_ln;
                                if (modem) begin
                                    if ((d & mlsr_pkg::RXC_DSIE) == '0)
                                        ds_req_next = ds_req_reg & ~bit_ln;
                                    else if ((csr & (mlsr_pkg::RXC_DSI | mlsr_pkg::RXC_DSIE))
                                             == mlsr_pkg::RXC_DSI)
                                        ds_req_next = ds_req_reg | bit_ln;
                                    if (((d ^ csr) & mlsr_pkg::RXC_DTR) != '0) begin
                                        if ((d & mlsr_pkg::RXC_DTR) != '0 && conn) begin
                                            csr = (csr & ~mlsr_pkg::RXC_RNG) | mlsr_pkg::RXC_CDT
                                                | mlsr_pkg::RXC_CTS | mlsr_pkg::RXC_DSI;
                                            if ((d & mlsr_pkg::RXC_DSIE) != '0)
                                                ds_req_next = ds_req_next | bit_ln;
                                        end else begin
                                            if (conn) begin
                                                out_next.hangup = 1'b1;
                                                conn_next = conn_reg & ~bit_ln;
                                                if ((csr & mlsr_pkg::RXC_CDT) != '0) begin
                                                    csr = csr | mlsr_pkg::RXC_DSI;
                                                    if ((d & mlsr_pkg::RXC_DSIE) != '0)
                                                        ds_req_next = ds_req_next | bit_ln;
                                                end
                                            end
                                            csr = csr & ~(mlsr_pkg::RXC_CDT | mlsr_pkg::RXC_RNG
                                                        | mlsr_pkg::RXC_CTS);
                                        end
                                    end
                                    csr = (csr & ~mlsr_pkg::RXC_WR_M) | (d & mlsr_pkg::RXC_WR_M);
                                end
                                csr = (csr & ~mlsr_pkg::RXC_WR) | (d & mlsr_pkg::RXC_WR);
                                rxs_next = csr;
                            end
                        end
                        mlsr_pkg::REG_RXBUF: ;
                        mlsr_pkg::REG_TXCSR: begin
                            if (!odd) begin
                                if ((d[7:0] & mlsr_pkg::TXC_IE) == '0)
                                    tx_req_next = tx_req_reg & ~bit_ln;
                                else if ((txs & (mlsr_pkg::TXC_DONE | mlsr_pkg::TXC_IE))
                                         == mlsr_pkg::TXC_DONE)
                                    tx_req_next = tx_req_reg | bit_ln;
                                txs_next = (txs & ~mlsr_pkg::TXC_WR) | (d[7:0] & mlsr_pkg::TXC_WR);
                            end
                        end
                        default: begin
                            if (!odd) txb_next = d[7:0];
                            txs_next = txs & ~mlsr_pkg::TXC_DONE;
                            tx_req_next = tx_req_reg & ~bit_ln;
                        end
                    endcase
                end
            end
            mlsr_pkg::OP_RX_CHAR, mlsr_pkg::OP_RX_BREAK: begin
                if (ev_ok && conn) begin
                    wr_line = 1'b1;
                    c = (in_reg.opcode == mlsr_pkg::OP_RX_CHAR)
                      ? {8'd0, in_reg.rx_char} : (mlsr_pkg::RXB_ERR | mlsr_pkg::RXB_BRK);
                    if ((rxs & mlsr_pkg::RXC_DONE) != '0)
                        c = c | mlsr_pkg::RXB_ERR | mlsr_pkg::RXB_OVR;
                    rxs_next = rxs | mlsr_pkg::RXC_DONE;
                    if ((rxs & mlsr_pkg::CSR_IE) != '0) rx_req_next = rx_req_reg | bit_ln;
                    rxb_next = c;
                end
            end
            mlsr_pkg::OP_TX_DONE: begin
                if (ev_ok) begin
                    wr_line = 1'b1;
                    if (conn) begin
                        out_next.tx_valid = 1'b1;
                        out_next.tx_char  = txb;
                    end
                    txs_next = txs | mlsr_pkg::TXC_DONE;
                    if ((txs & mlsr_pkg::TXC_IE) != '0) tx_req_next = tx_req_reg | bit_ln;
                end
            end
            mlsr_pkg::OP_CONNECT: begin
                if (ev_ok && !conn) begin
                    wr_line = 1'b1;
                    conn_next = conn_reg | bit_ln;
                    if (modem) begin
                        if ((rxs & mlsr_pkg::RXC_DTR) != '0)
                            csr = rxs | mlsr_pkg::RXC_CDT | mlsr_pkg::RXC_CTS | mlsr_pkg::RXC_DSI;
                        else
                            csr = rxs | mlsr_pkg::RXC_RNG | mlsr_pkg::RXC_DSI;
                        if ((csr & mlsr_pkg::RXC_DSIE) != '0) ds_req_next = ds_req_reg | bit_ln;
                        rxs_next = csr;
                    end
                end
            end
            mlsr_pkg::OP_DISCONN: begin
                if (ev_ok) begin
                    wr_line = 1'b1;
                    conn_next = conn_reg & ~bit_ln;
                    if (modem) begin
                        if ((csr & mlsr_pkg::RXC_CDT) != '0) begin
                            csr = csr | mlsr_pkg::RXC_DSI;
                            if ((csr & mlsr_pkg::RXC_DSIE) != '0)
                                ds_req_next = ds_req_reg | bit_ln;
                        end
                        rxs_next = csr & ~(mlsr_pkg::RXC_CDT | mlsr_pkg::RXC_RNG
                                         | mlsr_pkg::RXC_CTS);
                    end
                end
            end
            mlsr_pkg::OP_RX_IACK: begin
                if (rx_pick.found) begin
                    rx_req_next = rx_req_reg & ~(NUM_LINES'(1) << rx_pick.idx[LW-1:0]);
                    ds_req_next = ds_req_reg & ~(NUM_LINES'(1) << rx_pick.idx[LW-1:0]);
                    out_next.vector = {1'b0, base_vec_reg}
                                    + 10'(rx_pick.idx) * mlsr_pkg::LINE_SPAN;
                    out_next.vector_valid = 1'b1;
                end
            end
            mlsr_pkg::OP_TX_IACK: begin
                if (tx_pick.found) begin
                    tx_req_next = tx_req_reg & ~(NUM_LINES'(1) << tx_pick.idx[LW-1:0]);
                    out_next.vector = {1'b0, base_vec_reg}
                                    + 10'(tx_pick.idx) * mlsr_pkg::LINE_SPAN
                                    + mlsr_pkg::TX_VEC_OFS;
                    out_next.vector_valid = 1'b1;
                end
            end
            default: ;
        endcase
        out_next.rx_irq = |(rx_req_next | ds_req_next);
        out_next.tx_irq = |tx_req_next;
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_req_reg <= '0;
            ds_req_reg <= '0;
            tx_req_reg <= '0;
            conn_reg   <= '0;
            for (int i = 0; i < NUM_LINES; i++) begin
                rx_status_reg[i] <= '0;
                rx_buffer_reg[i] <= '0;
                tx_status_reg[i] <= mlsr_pkg::TXC_DONE;
                tx_buffer_reg[i] <= '0;
            end
        end else if (advance) begin
            rx_req_reg <= rx_req_next;
            ds_req_reg <= ds_req_next;
            tx_req_reg <= tx_req_next;
            conn_reg   <= conn_next;
            if (wr_line) begin
                rx_status_reg[ln] <= rxs_next;
                rx_buffer_reg[ln] <= rxb_next;
                tx_status_reg[ln] <= txs_next;
                tx_buffer_reg[ln] <= txb_next;
            end
        end
    end

    assign m_valid        = out_full_reg;
    assign m_read_data    = out_reg.read_data;
    assign m_bus_error    = out_reg.bus_error;
    assign m_rx_irq       = out_reg.rx_irq;
    assign m_tx_irq       = out_reg.tx_irq;
    assign m_vector       = out_reg.vector;
    assign m_vector_valid = out_reg.vector_valid;
    assign m_tx_valid     = out_reg.tx_valid;
    assign m_tx_char      = out_reg.tx_char;
    assign m_hangup       = out_reg.hangup;
endmodule

### hdl/mlsr_checker.sv
module mlsr_props (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_bus_error,
    input logic [15:0] m_read_data,
    input logic [9:0] m_vector,
    input logic       m_vector_valid,
    input logic       m_tx_valid,
    input logic [7:0] m_tx_char
);
    // a stalled result word stays valid and holds its read data and vector
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data) && $stable(m_vector))
        else $error("result word changed while stalled");

    // a bus error returns no data and no vector
    a_berr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_bus_error |-> m_read_data == 16'd0 && !m_vector_valid)
        else $error("bus error with data");

    // no vector without vector valid
    a_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_vector_valid |-> m_vector == 10'd0)
        else $error("vector without valid");

    // no character without a send
    a_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tx_valid |-> m_tx_char == 8'd0)
        else $error("tx char without tx valid");
endmodule

bind multiline_serial_register_file_unit mlsr_props u_mlsr_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_bus_error   (m_bus_error),
    .m_read_data   (m_read_data),
    .m_vector      (m_vector),
    .m_vector_valid(m_vector_valid),
    .m_tx_valid    (m_tx_valid),
    .m_tx_char     (m_tx_char)
);
